// ===== src/sss_pkg.sv =====
// shared types and constants for the stream string substitute block
package sss_pkg;

    localparam int ADDR_W      = 5;
    localparam int DATA_W      = 64;
    localparam int MAX_RESULTS = 8;
    localparam int RES_IDX_W   = 3;

    // register index, taken from paddr[4:3]
    typedef enum logic [1:0] {
        REG_PATTERN_BYTES     = 2'd0,
        REG_PATTERN_LENGTH    = 2'd1,
        REG_REPLACEMENT_BYTES = 2'd2,
        REG_REPLACEMENT_LENGTH = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [63:0] pat_bytes;
        logic [3:0]  pat_len;
        logic [63:0] rep_bytes;
        logic [3:0]  rep_len;
    } t_cfg;

    // one group of results produced by a single input byte
    typedef struct packed {
        logic [MAX_RESULTS-1:0][7:0] bytes;
        logic [3:0]                  cnt;
        logic                        fin;
    } t_res;

endpackage

// ===== src/stream_string_substitute_top.sv =====
// top level of the streaming find-and-replace block
// Streaming find-and-replace: every leftmost, non-overlapping occurrence of the configured
// pattern (1 to MAX_PATTERN bytes) in the input byte stream is replaced by the configured
// replacement (1 to 8 bytes); scanning resumes after the inserted text, and the byte marked
// tlast flushes the match window and ends the output text (output tlast). Each input byte
// is registered, run through combinational window insert/compare logic and turned into
// 0 to 8 result bytes; a non-empty group goes to a result register, which drains one byte
// per cycle while output is ready, so ordinary text flows at one byte per cycle; output
// tuser marks the last byte caused by one input byte. A byte that yields several results
// holds the input until the result register has handed them all out through its single
// output port. Lengths of zero count as one and larger values saturate. Writing the
// pattern length drops buffered bytes; write registers only while idle (not enforced).
module stream_string_substitute_top
    import sss_pkg::*;
#(
    parameter int MAX_PATTERN = 8
)
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input stream
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [7:0]        i_s_axis_tdata,   // [7:0] in_byte
    input  logic              i_s_axis_tlast,   // in_final
    // output stream
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [7:0]        o_m_axis_tdata,   // [7:0] out_byte
    output logic              o_m_axis_tuser,   // [0] run_end
    output logic              o_m_axis_tlast,   // text_end
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    t_cfg w_cfg;
    logic w_wc_clr;
    logic w_res_free;
    logic w_res_load;
    t_res w_res;

    // register file; pattern length writes also clear the window
    sss_cfg u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_cfg    (w_cfg),
        .o_wc_clr (w_wc_clr)
    );

    // input register plus window logic, one request per cycle when the result side is free
    sss_core #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_wc_clr   (w_wc_clr),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .i_s_byte   (i_s_axis_tdata),
        .i_s_final  (i_s_axis_tlast),
        .i_res_free (w_res_free),
        .o_res_load (w_res_load),
        .o_res      (w_res)
    );

    // result register; frees up in the cycle its last byte is taken
    sss_out u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (w_res_load),
        .i_res        (w_res),
        .o_free       (w_res_free),
        .o_m_tvalid   (o_m_axis_tvalid),
        .i_m_tready   (i_m_axis_tready),
        .o_m_byte     (o_m_axis_tdata),
        .o_m_run_end  (o_m_axis_tuser),
        .o_m_text_end (o_m_axis_tlast)
    );

    // text end only ever comes with run end
    a_text_end_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tlast) |-> o_m_axis_tuser)
        else $error("text end without run end");

endmodule

// ===== src/sss_cfg.sv =====
// configuration register file with apb-style access
module sss_cfg
    import sss_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg,
    output logic              o_wc_clr
);

    logic [63:0] r_pat_bytes;
    logic [3:0]  r_pat_len;
    logic [63:0] r_rep_bytes;
    logic [3:0]  r_rep_len;
    logic        w_wr;
    t_reg_idx    w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = t_reg_idx'(paddr[4:3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_bytes <= '0;
            r_pat_len   <= 4'd1;
            r_rep_bytes <= '0;
            r_rep_len   <= 4'd1;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_PATTERN_BYTES:      r_pat_bytes <= pwdata;
                REG_PATTERN_LENGTH:     r_pat_len   <= pwdata[3:0];
                REG_REPLACEMENT_BYTES:  r_rep_bytes <= pwdata;
                REG_REPLACEMENT_LENGTH: r_rep_len   <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_PATTERN_BYTES:      prdata = r_pat_bytes;
            REG_PATTERN_LENGTH:     prdata = {60'd0, r_pat_len};
            REG_REPLACEMENT_BYTES:  prdata = r_rep_bytes;
            REG_REPLACEMENT_LENGTH: prdata = {60'd0, r_rep_len};
            default:                prdata = '0;
        endcase
    end

    // a new pattern length drops whatever is buffered
    assign o_wc_clr = w_wr && (w_idx == REG_PATTERN_LENGTH);

    assign o_cfg.pat_bytes = r_pat_bytes;
    assign o_cfg.pat_len   = r_pat_len;
    assign o_cfg.rep_bytes = r_rep_bytes;
    assign o_cfg.rep_len   = r_rep_len;

endmodule

// ===== src/sss_core.sv =====
// input register, match window and per-byte result computation
module sss_core
    import sss_pkg::*;
#(
    parameter int MAX_PATTERN = 8
)
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_wc_clr,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_byte,
    input  logic       i_s_final,
    input  logic       i_res_free,
    output logic       o_res_load,
    output t_res       o_res
);

    localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int CNT_W = $clog2(MAX_PATTERN + 1);

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_in_final;
    logic [7:0]       r_win [MAX_PATTERN];
    logic [CNT_W-1:0] r_wc;

    logic [3:0]       w_plen;
    logic [3:0]       w_rlen;
    logic [CNT_W-1:0] w_wc0;
    logic [3:0]       w_wc1;
    logic [7:0]       w_win [MAX_PATTERN];
    logic             w_full;
    logic             w_match;
    logic             w_consume;
    t_res             w_res;

    // effective lengths: zero counts as one, saturate at the limits
    always_comb begin
        if (i_cfg.pat_len == 4'd0) begin
            w_plen = 4'd1;
        end else if (i_cfg.pat_len > 4'(MAX_PATTERN)) begin
            w_plen = 4'(MAX_PATTERN);
        end else begin
            w_plen = i_cfg.pat_len;
        end
        if (i_cfg.rep_len == 4'd0) begin
            w_rlen = 4'd1;
        end else if (i_cfg.rep_len > 4'(MAX_RESULTS)) begin
            w_rlen = 4'(MAX_RESULTS);
        end else begin
            w_rlen = i_cfg.rep_len;
        end
    end

    // insert the new byte, then test the window
    always_comb begin
        w_wc0 = (4'(r_wc) >= w_plen) ? '0 : r_wc;
        w_win = r_win;
        w_win[w_wc0[IDX_W-1:0]] = r_in_byte;
        w_wc1  = 4'(w_wc0) + 4'd1;
        w_full = (w_wc1 == w_plen);
        w_match = w_full;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            if ((4'(i) < w_plen) && (w_win[i] != i_cfg.pat_bytes[8*i +: 8])) begin
                w_match = 1'b0;
            end
        end
    end

    // on a match the replacement, otherwise the window front (one byte, a flush, or none)
    always_comb begin
        for (int i = 0; i < MAX_RESULTS; i++) begin
            w_res.bytes[i] = w_match ? i_cfg.rep_bytes[8*i +: 8] : 8'd0;
        end
        if (!w_match) begin
            for (int i = 0; i < MAX_PATTERN; i++) begin
                w_res.bytes[i] = w_win[i];
            end
        end
        priority if (w_match) begin
            w_res.cnt = w_rlen;
        end else if (r_in_final) begin
            w_res.cnt = w_wc1;
        end else if (w_full) begin
            w_res.cnt = 4'd1;
        end else begin
            w_res.cnt = 4'd0;
        end
        w_res.fin = r_in_final;
    end

    assign w_consume  = r_in_valid && ((w_res.cnt == 4'd0) || i_res_free);
    assign o_s_tready = !r_in_valid || w_consume;
    assign o_res_load = w_consume && (w_res.cnt != 4'd0);
    assign o_res      = w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_wc       <= '0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (i_wc_clr) begin
                r_wc <= '0;
            end else if (w_consume) begin
                priority if (w_match || r_in_final) begin
                    r_wc <= '0;
                end else if (w_full) begin
                    r_wc <= CNT_W'(w_wc1 - 4'd1);
                end else begin
                    r_wc <= CNT_W'(w_wc1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_byte  <= i_s_byte;
            r_in_final <= i_s_final;
        end
        if (w_consume) begin
            if (w_full && !w_match && !r_in_final) begin
                for (int i = 0; i < MAX_PATTERN - 1; i++) begin
                    r_win[i] <= w_win[i+1];
                end
                r_win[MAX_PATTERN-1] <= w_win[MAX_PATTERN-1];
            end else begin
                r_win <= w_win;
            end
        end
    end

    // a final byte always produces at least one result
    a_final_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_consume && r_in_final) |-> o_res_load)
        else $error("final byte consumed without results");

    // the window count stays below the pattern limit
    a_wc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        4'(r_wc) < 4'(MAX_PATTERN))
        else $error("window count out of range");

endmodule

// ===== src/sss_out.sv =====
// result register that hands out one byte per request
module sss_out
    import sss_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  t_res       i_res,
    output logic       o_free,
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_byte,
    output logic       o_m_run_end,
    output logic       o_m_text_end
);

    logic                        r_valid;
    logic [MAX_RESULTS-1:0][7:0] r_bytes;
    logic [3:0]                  r_cnt;
    logic [RES_IDX_W-1:0]        r_idx;
    logic                        r_fin;
    logic                        w_last;

    assign w_last       = ({1'b0, r_idx} + 4'd1) == r_cnt;
    assign o_free       = !r_valid || (i_m_tready && w_last);
    assign o_m_tvalid   = r_valid;
    assign o_m_byte     = r_bytes[r_idx];
    assign o_m_run_end  = w_last;
    assign o_m_text_end = w_last && r_fin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_idx   <= '0;
        end else if (r_valid && i_m_tready) begin
            if (w_last) begin
                r_valid <= 1'b0;
            end else begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bytes <= i_res.bytes;
            r_cnt   <= i_res.cnt;
            r_fin   <= i_res.fin;
        end
    end

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> ({1'b0, r_idx} < r_cnt))
        else $error("result index beyond result count");

    // nothing is loaded over a group still being handed out
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_free)
        else $error("result group overwritten");

endmodule
